FILE: rtl/pnc_pkg.sv
// Shared types and constants for the perfect number checker.
package pnc_pkg;

   localparam int NUM_WIDTH_DEF = 32;
   // Headroom bits for sigma(n), which stays below 16 * n for any supported width.
   localparam int SUM_MARGIN    = 4;
   localparam int SUM_OUT_WIDTH = 36;

   typedef enum logic [11:0] {
      S_IDLE          = 12'b0000_0000_0001,
      S_DIVO          = 12'b0000_0000_0010,
      S_DIVO_WAIT     = 12'b0000_0000_0100,
      S_MUL_TERM      = 12'b0000_0000_1000,
      S_MUL_TERM_WAIT = 12'b0000_0001_0000,
      S_DIVI          = 12'b0000_0010_0000,
      S_DIVI_WAIT     = 12'b0000_0100_0000,
      S_MUL_SIG       = 12'b0000_1000_0000,
      S_MUL_SIG_WAIT  = 12'b0001_0000_0000,
      S_FINAL         = 12'b0010_0000_0000,
      S_FIN_WAIT      = 12'b0100_0000_0000,
      S_DONE          = 12'b1000_0000_0000
   } state_type;

   typedef enum logic [1:0] {
      MUL_TERM     = 2'd0,  // term  = term * p + 1
      MUL_SIG_TERM = 2'd1,  // sigma = sigma * term
      MUL_SIG_REST = 2'd2   // sigma = sigma * (rest + 1)
   } mul_sel_type;

   typedef struct packed {
      logic        load;
      logic        take_q;
      logic        next_p;
      logic        term_init;
      logic        div_start;
      logic        mul_start;
      mul_sel_type mul_sel;
      logic        finish;
   } cmd_type;

   typedef struct packed {
      logic div_busy;
      logic mul_busy;
      logic q_ge_p;
      logic rem_zero;
      logic rest_gt1;
      logic out_busy;
   } status_type;

endpackage

FILE: rtl/pnc_ctrl.sv
// Sequencer for the factorization loop of the perfect number checker.
module pnc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  pnc_pkg::status_type status,
   output pnc_pkg::cmd_type    cmd
);

   pnc_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pnc_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      cmd.mul_sel   = pnc_pkg::MUL_TERM;
      req_ready     = 1'b0;
      case (state_ff)
         pnc_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = pnc_pkg::S_DIVO;
            end
         end
         // outer loop: test the next candidate against the cofactor
         pnc_pkg::S_DIVO: begin
            cmd.div_start = 1'b1;
            state_in      = pnc_pkg::S_DIVO_WAIT;
         end
         pnc_pkg::S_DIVO_WAIT: begin
            if (!status.div_busy) begin
               if (!status.q_ge_p) begin
                  state_in = pnc_pkg::S_FINAL;
               end else if (status.rem_zero) begin
                  cmd.take_q    = 1'b1;
                  cmd.term_init = 1'b1;
                  state_in      = pnc_pkg::S_MUL_TERM;
               end else begin
                  cmd.next_p = 1'b1;
                  state_in   = pnc_pkg::S_DIVO;
               end
            end
         end
         pnc_pkg::S_MUL_TERM: begin
            cmd.mul_start = 1'b1;
            cmd.mul_sel   = pnc_pkg::MUL_TERM;
            state_in      = pnc_pkg::S_MUL_TERM_WAIT;
         end
         pnc_pkg::S_MUL_TERM_WAIT: begin
            if (!status.mul_busy) begin
               state_in = pnc_pkg::S_DIVI;
            end
         end
         // inner loop: strip further powers of the same prime
         pnc_pkg::S_DIVI: begin
            cmd.div_start = 1'b1;
            state_in      = pnc_pkg::S_DIVI_WAIT;
         end
         pnc_pkg::S_DIVI_WAIT: begin
            if (!status.div_busy) begin
               if (status.rem_zero) begin
                  cmd.take_q = 1'b1;
                  state_in   = pnc_pkg::S_MUL_TERM;
               end else begin
                  state_in = pnc_pkg::S_MUL_SIG;
               end
            end
         end
         pnc_pkg::S_MUL_SIG: begin
            cmd.mul_start = 1'b1;
            cmd.mul_sel   = pnc_pkg::MUL_SIG_TERM;
            cmd.next_p    = 1'b1;
            state_in      = pnc_pkg::S_MUL_SIG_WAIT;
         end
         pnc_pkg::S_MUL_SIG_WAIT: begin
            if (!status.mul_busy) begin
               state_in = pnc_pkg::S_DIVO;
            end
         end
         // leftover cofactor above one is a prime of its own
         pnc_pkg::S_FINAL: begin
            if (status.rest_gt1) begin
               cmd.mul_start = 1'b1;
               cmd.mul_sel   = pnc_pkg::MUL_SIG_REST;
               state_in      = pnc_pkg::S_FIN_WAIT;
            end else begin
               state_in = pnc_pkg::S_DONE;
            end
         end
         pnc_pkg::S_FIN_WAIT: begin
            if (!status.mul_busy) begin
               state_in = pnc_pkg::S_DONE;
            end
         end
         pnc_pkg::S_DONE: begin
            if (!status.out_busy) begin
               cmd.finish = 1'b1;
               state_in   = pnc_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = pnc_pkg::S_IDLE;
         end
      endcase
   end

endmodule

FILE: rtl/pnc_datapath.sv
// Datapath: cofactor registers, restoring divider, shift-add multiplier, result register.
module pnc_datapath #(
   parameter int NUM_WIDTH = pnc_pkg::NUM_WIDTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [NUM_WIDTH-1:0]                  req_number,
   input  logic                                  rsp_ready,
   output logic                                  rsp_valid,
   output logic                                  rsp_is_perfect,
   output logic [pnc_pkg::SUM_OUT_WIDTH-1:0]     rsp_divisor_sum,
   input  pnc_pkg::cmd_type                      cmd,
   output pnc_pkg::status_type                   status
);

   localparam int SW    = NUM_WIDTH + pnc_pkg::SUM_MARGIN;
   localparam int CNT_W = $clog2(NUM_WIDTH + 1);
   localparam int OUT_W = pnc_pkg::SUM_OUT_WIDTH;
   localparam int EXT_W = (SW > OUT_W) ? SW : OUT_W;

   logic [NUM_WIDTH-1:0] n_ff, n_in;
   logic [NUM_WIDTH-1:0] rest_ff, rest_in;
   logic [NUM_WIDTH-1:0] p_ff, p_in;
   logic [SW-1:0]        sigma_ff, sigma_in;
   logic [SW-1:0]        term_ff, term_in;

   logic [NUM_WIDTH-1:0] rem_ff, rem_in;
   logic [NUM_WIDTH-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0]     dcnt_ff, dcnt_in;
   logic                 div_busy_ff, div_busy_in;

   logic [SW-1:0]        ma_ff, ma_in;
   logic [SW-1:0]        mb_ff, mb_in;
   logic [SW-1:0]        acc_ff, acc_in;
   logic                 mul_busy_ff, mul_busy_in;
   pnc_pkg::mul_sel_type mul_sel_ff, mul_sel_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 perfect_ff, perfect_in;
   logic [OUT_W-1:0]     sum_out_ff, sum_out_in;

   logic [NUM_WIDTH:0]   trial;
   logic [NUM_WIDTH:0]   trial_diff;
   logic                 trial_ge;
   logic [SW-1:0]        aliquot;
   logic [EXT_W-1:0]     aliquot_ext;

   // one quotient bit per cycle
   assign trial      = {rem_ff, quo_ff[NUM_WIDTH-1]};
   assign trial_diff = trial - {1'b0, p_ff};
   assign trial_ge   = (trial >= {1'b0, p_ff});

   assign aliquot     = (n_ff < NUM_WIDTH'(2)) ? '0 : (sigma_ff - SW'(n_ff));
   assign aliquot_ext = EXT_W'(aliquot);

   assign status.div_busy = div_busy_ff;
   assign status.mul_busy = mul_busy_ff;
   assign status.q_ge_p   = (p_ff <= quo_ff);
   assign status.rem_zero = (rem_ff == '0);
   assign status.rest_gt1 = (rest_ff > NUM_WIDTH'(1));
   assign status.out_busy = rsp_valid_ff && !rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_is_perfect  = perfect_ff;
   assign rsp_divisor_sum = sum_out_ff;

   always_comb begin
      n_in         = n_ff;
      rest_in      = rest_ff;
      p_in         = p_ff;
      sigma_in     = sigma_ff;
      term_in      = term_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      dcnt_in      = dcnt_ff;
      div_busy_in  = div_busy_ff;
      ma_in        = ma_ff;
      mb_in        = mb_ff;
      acc_in       = acc_ff;
      mul_busy_in  = mul_busy_ff;
      mul_sel_in   = mul_sel_ff;
      rsp_valid_in = rsp_valid_ff;
      perfect_in   = perfect_ff;
      sum_out_in   = sum_out_ff;

      if (cmd.load) begin
         n_in     = req_number;
         rest_in  = req_number;
         p_in     = NUM_WIDTH'(2);
         sigma_in = SW'(1);
      end
      if (cmd.take_q) begin
         rest_in = quo_ff;
      end
      if (cmd.next_p) begin
         p_in = (p_ff == NUM_WIDTH'(2)) ? NUM_WIDTH'(3) : p_ff + NUM_WIDTH'(2);
      end
      if (cmd.term_init) begin
         term_in = SW'(1);
      end

      if (cmd.div_start) begin
         rem_in      = '0;
         quo_in      = rest_ff;
         dcnt_in     = CNT_W'(NUM_WIDTH);
         div_busy_in = 1'b1;
      end else if (div_busy_ff) begin
         rem_in  = trial_ge ? trial_diff[NUM_WIDTH-1:0] : trial[NUM_WIDTH-1:0];
         quo_in  = {quo_ff[NUM_WIDTH-2:0], trial_ge};
         dcnt_in = dcnt_ff - CNT_W'(1);
         if (dcnt_ff == CNT_W'(1)) begin
            div_busy_in = 1'b0;
         end
      end

      if (cmd.mul_start) begin
         acc_in      = '0;
         mul_sel_in  = cmd.mul_sel;
         mul_busy_in = 1'b1;
         case (cmd.mul_sel)
            pnc_pkg::MUL_TERM: begin
               ma_in = term_ff;
               mb_in = SW'(p_ff);
            end
            pnc_pkg::MUL_SIG_TERM: begin
               ma_in = sigma_ff;
               mb_in = term_ff;
            end
            pnc_pkg::MUL_SIG_REST: begin
               ma_in = sigma_ff;
               mb_in = SW'(rest_ff) + SW'(1);
            end
            default: begin
               ma_in = '0;
               mb_in = '0;
            end
         endcase
      end else if (mul_busy_ff) begin
         if (mb_ff == '0) begin
            // multiplier drained: write back to its destination
            mul_busy_in = 1'b0;
            case (mul_sel_ff)
               pnc_pkg::MUL_TERM:     term_in  = acc_ff + SW'(1);
               pnc_pkg::MUL_SIG_TERM: sigma_in = acc_ff;
               pnc_pkg::MUL_SIG_REST: sigma_in = acc_ff;
               default:               sigma_in = sigma_ff;
            endcase
         end else begin
            acc_in = acc_ff + (mb_ff[0] ? ma_ff : '0);
            ma_in  = {ma_ff[SW-2:0], 1'b0};
            mb_in  = {1'b0, mb_ff[SW-1:1]};
         end
      end

      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         sum_out_in   = aliquot_ext[OUT_W-1:0];
         perfect_in   = (n_ff != '0) && (aliquot == SW'(n_ff));
      end else if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_busy_ff  <= 1'b0;
         mul_busy_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         div_busy_ff  <= div_busy_in;
         mul_busy_ff  <= mul_busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff       <= n_in;
      rest_ff    <= rest_in;
      p_ff       <= p_in;
      sigma_ff   <= sigma_in;
      term_ff    <= term_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      dcnt_ff    <= dcnt_in;
      ma_ff      <= ma_in;
      mb_ff      <= mb_in;
      acc_ff     <= acc_in;
      mul_sel_ff <= mul_sel_in;
      perfect_ff <= perfect_in;
      sum_out_ff <= sum_out_in;
   end

endmodule

FILE: rtl/perfect_number_checker.sv
// Top level of the perfect number checker.
// Each request beat carries one unsigned number; one response beat returns the sum of
// its proper divisors and a flag set when that sum equals the number (0 and 1 give a sum
// of 0 and are not perfect). The sum is built from the prime factorization by trial
// division, one candidate at a time, through a restoring divider that yields one quotient
// bit per cycle; candidates run over 2 and the odd numbers up to the square root of the
// remaining cofactor. Each prime power found adds a division and a shift-add
// multiplication. A prime near 2^32 needs about 2^15 candidates. One number is worked
// on at a time; a new request is taken as soon as the previous result sits in the output
// register, even if that result has not yet been taken.
module perfect_number_checker #(
   parameter int NUM_WIDTH = pnc_pkg::NUM_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [NUM_WIDTH-1:0]              req_number,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_is_perfect,
   output logic [pnc_pkg::SUM_OUT_WIDTH-1:0] rsp_divisor_sum
);

   pnc_pkg::cmd_type    cmd;
   pnc_pkg::status_type status;

   pnc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   pnc_datapath #(
      .NUM_WIDTH (NUM_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_number      (req_number),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_is_perfect  (rsp_is_perfect),
      .rsp_divisor_sum (rsp_divisor_sum),
      .cmd             (cmd),
      .status          (status)
   );

endmodule

FILE: rtl/pnc_checker.sv
// Port-level checks for the perfect number checker, bound to the top level.
module pnc_checker #(
   parameter int NUM_WIDTH = pnc_pkg::NUM_WIDTH_DEF
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic [NUM_WIDTH-1:0]              req_number,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic                              rsp_is_perfect,
   input logic [pnc_pkg::SUM_OUT_WIDTH-1:0] rsp_divisor_sum
);

   localparam int OW = pnc_pkg::SUM_OUT_WIDTH;

   // a stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_divisor_sum)
         && $stable(rsp_is_perfect))
      else $error("response beat changed while stalled");

   // a waiting request beat holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_number))
      else $error("request beat changed while waiting");

   // one number at a time: busy right after a request beat
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a number is in work");

   // a perfect number is at least 6, and its divisor sum equals it
   a_perfect_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_perfect |-> rsp_divisor_sum >= OW'(6))
      else $error("perfect flag with an impossible divisor sum");

   // leaving reset: no result pending, ready for a request
   a_reset_state: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid && req_ready)
      else $error("bad state after reset");

endmodule

bind perfect_number_checker pnc_checker #(.NUM_WIDTH(NUM_WIDTH)) u_pnc_checker (.*);
